>>> hw/rtl/vrtiu_pkg.sv
// shared types and constants for the raster timing and interrupt unit
package vrtiu_pkg;

    // register window
    localparam int REGISTER_COUNT = 64;
    localparam int OFFSET_W       = 6;
    localparam int REG_AW         = $clog2(REGISTER_COUNT);

    // request kinds
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    // special register offsets
    localparam logic [OFFSET_W-1:0] REG_CTRL   = 6'h11;
    localparam logic [OFFSET_W-1:0] REG_RASTER = 6'h12;
    localparam logic [OFFSET_W-1:0] REG_FLAGS  = 6'h19;
    localparam logic [OFFSET_W-1:0] REG_ENABLE = 6'h1A;

    // configuration register index
    localparam logic CFG_NTSC_MODEL = 1'b0;

    // frame geometry
    localparam logic [6:0] CYCLES_PAL  = 7'd63;
    localparam logic [6:0] CYCLES_NTSC = 7'd65;
    localparam logic [8:0] LINES_PAL   = 9'd312;
    localparam logic [8:0] LINES_NTSC  = 9'd263;

    // bad line window and display enable tracking
    localparam logic [8:0] BADLINE_FIRST = 9'h030;
    localparam logic [8:0] BADLINE_LAST  = 9'h0F7;
    localparam logic [8:0] DEN_LINE      = 9'h02F;
    localparam logic [6:0] STALL_READ_X  = 7'd11;
    localparam logic [6:0] STALL_FULL_X  = 7'd14;
    localparam logic [6:0] STALL_LAST_X  = 7'd53;

    // stall levels
    localparam logic [1:0] STALL_NONE = 2'd0;
    localparam logic [1:0] STALL_RD   = 2'd1;
    localparam logic [1:0] STALL_FULL = 2'd2;

    // reset values
    localparam logic [7:0] CTRL_RST   = 8'h9B;
    localparam logic [7:0] RASTER_RST = 8'h37;
    localparam logic [7:0] FLAGS_RST  = 8'h01;

endpackage

>>> hw/rtl/video_raster_timing_irq_unit_core.sv
// raster timing, raster interrupt and bad line stall core
//
//  channel   dir   handshake          payload
//  s_        in    s_valid/s_ready    s_command, s_register_offset, s_write_data
//  m_        out   m_valid/m_ready    m_read_data, m_irq_out, m_stall_level,
//                                     m_raster_line, m_raster_cycle
//  apb       in    psel/penable       paddr, pwdata, prdata (ntsc_model)
//
// one request per cycle unless a stalled result register holds the pipe
// the request is registered together with the generic register memory read,
// then one pass of compare and update logic writes state and the result register
// reset is synchronous and puts the beam at the last cycle of the last PAL line
// a stalled result register holds the pipe; s_ready drops only when both stages are full
module video_raster_timing_irq_unit_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_command,
    input  logic [vrtiu_pkg::OFFSET_W-1:0] s_register_offset,
    input  logic [7:0]                    s_write_data,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_read_data,
    output logic                          m_irq_out,
    output logic [1:0]                    m_stall_level,
    output logic [8:0]                    m_raster_line,
    output logic [6:0]                    m_raster_cycle,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import vrtiu_pkg::*;

    // handshake
    logic s_acc;
    logic advance;
    logic cfg_wr;

    // request stage
    logic                p_valid_reg;
    logic [1:0]          p_cmd_reg;
    logic [OFFSET_W-1:0] p_off_reg;
    logic [7:0]          p_wdata_reg;
    logic [7:0]          p_mem_reg;
    logic                p_mem_vld_reg;

    // generic register memory
    logic [7:0]                mem [REGISTER_COUNT];
    logic [REGISTER_COUNT-1:0] mem_vld_reg;
    logic [REG_AW-1:0]         s_idx;
    logic                      s_off_ok;
    logic                      s_special;
    logic                      mem_wr;

    // timing and interrupt state
    logic       ntsc_reg;
    logic [6:0] cyc_reg,    cyc_next;
    logic [8:0] line_reg,   line_next;
    logic [7:0] ctrl_reg,   ctrl_next;
    logic [7:0] raster_reg, raster_next;
    logic [7:0] flags_reg,  flags_next;
    logic [7:0] enable_reg, enable_next;
    logic       den_reg,    den_next;
    logic       irq_reg,    irq_next;

    // processing
    logic [6:0] cpl;
    logic [8:0] lpf;
    logic [6:0] cyc_inc;
    logic [8:0] line_inc;
    logic [8:0] cmp_line;
    logic       chk_en;
    logic [8:0] chk_line;
    logic [7:0] flags_ack;
    logic       p_off_ok;
    logic [7:0] rd_next;
    logic [1:0] stall_next;

    // result register
    logic       m_valid_reg;
    logic [7:0] m_rd_reg;
    logic       m_irq_reg;
    logic [1:0] m_stall_reg;
    logic [8:0] m_line_reg;
    logic [6:0] m_cyc_reg;

    // pipe control
    assign advance = p_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !p_valid_reg || advance;
    assign s_acc   = s_valid && s_ready;
    assign cfg_wr  = psel && penable && pwrite && pready;

    // configuration readback
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr[2] == CFG_NTSC_MODEL) begin
            prdata = {31'd0, ntsc_reg};
        end
    end

    // generic register decode at accept
    assign s_idx     = s_register_offset[REG_AW-1:0];
    assign s_off_ok  = {1'b0, s_register_offset} < (OFFSET_W+1)'(REGISTER_COUNT);
    assign s_special = (s_register_offset == REG_CTRL) || (s_register_offset == REG_RASTER) ||
                       (s_register_offset == REG_FLAGS) || (s_register_offset == REG_ENABLE);
    assign mem_wr    = s_acc && (s_command == CMD_WRITE) && s_off_ok && !s_special;

    // generic register memory, written and read in request order
    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            mem[s_idx] <= s_write_data;
        end
        if (s_acc) begin
            p_mem_reg <= mem[s_idx];
        end
    end

    // valid bits for never written entries
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_vld_reg <= '0;
        end else if (mem_wr) begin
            mem_vld_reg[s_idx] <= 1'b1;
        end
    end

    // request stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (s_ready) begin
            p_valid_reg <= s_valid;
        end
        if (s_acc) begin
            p_cmd_reg     <= s_command;
            p_off_reg     <= s_register_offset;
            p_wdata_reg   <= s_write_data;
            p_mem_vld_reg <= mem_vld_reg[s_idx];
        end
    end

    // frame geometry and compare value
    assign cpl      = ntsc_reg ? CYCLES_NTSC : CYCLES_PAL;
    assign lpf      = ntsc_reg ? LINES_NTSC : LINES_PAL;
    assign cmp_line = {ctrl_reg[7], raster_reg};
    assign cyc_inc  = cyc_reg + 7'd1;
    assign line_inc = line_reg + 9'd1;
    assign p_off_ok = {1'b0, p_off_reg} < (OFFSET_W+1)'(REGISTER_COUNT);

    // one pass of tick, write or read
    always_comb begin
        cyc_next    = cyc_reg;
        line_next   = line_reg;
        ctrl_next   = ctrl_reg;
        raster_next = raster_reg;
        flags_next  = flags_reg;
        enable_next = enable_reg;
        den_next    = den_reg;
        irq_next    = irq_reg;
        chk_en      = 1'b0;
        chk_line    = line_reg;
        rd_next     = 8'd0;
        flags_ack   = flags_reg & ~p_wdata_reg;
        case (p_cmd_reg)
            CMD_TICK: begin
                cyc_next = cyc_inc;
                if ((cyc_inc == 7'd1) && (line_reg == 9'd0)) begin
                    chk_en   = 1'b1;
                    chk_line = line_reg;
                    den_next = ctrl_reg[4];
                end else if (cyc_inc >= cpl) begin
                    cyc_next  = 7'd0;
                    line_next = (line_inc >= lpf) ? 9'd0 : line_inc;
                    chk_en    = (line_next != 9'd0);
                    chk_line  = line_next;
                end
            end
            CMD_WRITE: begin
                if (p_off_ok) begin
                    case (p_off_reg)
                        REG_CTRL: begin
                            ctrl_next = p_wdata_reg;
                            if (line_reg < DEN_LINE) begin
                                den_next = p_wdata_reg[4];
                            end else if (line_reg == DEN_LINE) begin
                                den_next = den_reg | p_wdata_reg[4];
                            end
                        end
                        REG_RASTER: begin
                            raster_next = p_wdata_reg;
                        end
                        REG_FLAGS: begin
                            flags_next = flags_ack;
                            if (flags_ack[3:0] == 4'd0) begin
                                flags_next[7] = 1'b0;
                            end
                            irq_next = flags_next[7];
                        end
                        REG_ENABLE: begin
                            enable_next = p_wdata_reg;
                            if (p_wdata_reg[0] && flags_reg[0]) begin
                                irq_next      = 1'b1;
                                flags_next[7] = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            CMD_READ: begin
                if (p_off_ok) begin
                    case (p_off_reg)
                        REG_CTRL:   rd_next = {line_reg[8], ctrl_reg[6:0]};
                        REG_RASTER: rd_next = line_reg[7:0];
                        REG_FLAGS:  rd_next = flags_reg;
                        REG_ENABLE: rd_next = enable_reg;
                        default:    rd_next = p_mem_vld_reg ? p_mem_reg : 8'd0;
                    endcase
                end
            end
            default: begin
            end
        endcase

        // raster compare at line start
        if (chk_en && (chk_line == cmp_line)) begin
            flags_next[0] = 1'b1;
            if (enable_reg[0]) begin
                irq_next      = 1'b1;
                flags_next[7] = 1'b1;
            end
        end
    end

    // bad line stall at the new position
    always_comb begin
        stall_next = STALL_NONE;
        if (den_next && (line_next >= BADLINE_FIRST) && (line_next <= BADLINE_LAST) &&
            (line_next[2:0] == ctrl_next[2:0]) &&
            (cyc_next >= STALL_READ_X) && (cyc_next <= STALL_LAST_X)) begin
            stall_next = (cyc_next >= STALL_FULL_X) ? STALL_FULL : STALL_RD;
        end
    end

    // timing and interrupt state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ntsc_reg   <= 1'b0;
            cyc_reg    <= CYCLES_PAL - 7'd1;
            line_reg   <= LINES_PAL - 9'd1;
            ctrl_reg   <= CTRL_RST;
            raster_reg <= RASTER_RST;
            flags_reg  <= FLAGS_RST;
            enable_reg <= 8'd0;
            den_reg    <= 1'b1;
            irq_reg    <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[2] == CFG_NTSC_MODEL) begin
                ntsc_reg <= pwdata[0];
                cyc_reg  <= pwdata[0] ? (CYCLES_NTSC - 7'd1) : (CYCLES_PAL - 7'd1);
                line_reg <= pwdata[0] ? (LINES_NTSC - 9'd1) : (LINES_PAL - 9'd1);
            end
        end else if (advance) begin
            cyc_reg    <= cyc_next;
            line_reg   <= line_next;
            ctrl_reg   <= ctrl_next;
            raster_reg <= raster_next;
            flags_reg  <= flags_next;
            enable_reg <= enable_next;
            den_reg    <= den_next;
            irq_reg    <= irq_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance) begin
            m_rd_reg    <= rd_next;
            m_irq_reg   <= irq_next;
            m_stall_reg <= stall_next;
            m_line_reg  <= line_next;
            m_cyc_reg   <= cyc_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_read_data    = m_rd_reg;
    assign m_irq_out      = m_irq_reg;
    assign m_stall_level  = m_stall_reg;
    assign m_raster_line  = m_line_reg;
    assign m_raster_cycle = m_cyc_reg;

endmodule

>>> verif/tb_video_raster_timing_irq_unit_core.sv
// testbench for the raster timing and interrupt core: beam predictor, scoreboard and random traffic
module tb_video_raster_timing_irq_unit_core;
    import vrtiu_pkg::*;

    localparam logic [1:0] CMD_UNUSED      = 2'd3;
    localparam logic [2:0] ADDR_NTSC_MODEL = 3'(4 * CFG_NTSC_MODEL);
    localparam int         QUIET_LIMIT     = 2000;
    localparam int         IDLE_PCT        = 36;

    // one result as seen on the m_ side
    typedef struct packed {
        logic [7:0] rd;
        logic       irq;
        logic [1:0] stall;
        logic [8:0] line;
        logic [6:0] cyc;
    } beam_result_t;

    // beam and register predictor plus the queue of results still owed by the core
    class raster_scoreboard;
        logic             ntsc;
        logic [6:0]       beam_cycle;
        logic [8:0]       beam_line;
        logic [7:0]       reg_file [REGISTER_COUNT];
        logic             den_seen;
        logic             irq_line;
        beam_result_t     expected_results [$];
        int               errors;
        int               n_requests;
        int               n_checked;
        int               n_ticks;
        int               n_writes;
        int               n_reads;
        int               n_unused;
        int               n_matches;
        int               n_stall_rd;
        int               n_stall_full;
        int               n_irq_high;

        function new();
            foreach (reg_file[i]) reg_file[i] = '0;
            reg_file[REG_CTRL]   = CTRL_RST;
            reg_file[REG_RASTER] = RASTER_RST;
            reg_file[REG_FLAGS]  = FLAGS_RST;
            ntsc       = 1'b0;
            beam_cycle = CYCLES_PAL - 7'd1;
            beam_line  = LINES_PAL - 9'd1;
            den_seen   = 1'b1;
            irq_line   = 1'b0;
        endfunction

        function logic [6:0] line_cycles();
            return ntsc ? CYCLES_NTSC : CYCLES_PAL;
        endfunction

        function logic [8:0] frame_lines();
            return ntsc ? LINES_NTSC : LINES_PAL;
        endfunction

        // format change parks the beam so the next tick starts line 0
        function void select_format(logic ntsc_sel);
            ntsc       = ntsc_sel;
            beam_cycle = line_cycles() - 7'd1;
            beam_line  = frame_lines() - 9'd1;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // raster compare at the start of a line
        function void raster_match();
            logic [7:0] f;
            if (beam_line == {reg_file[REG_CTRL][7], reg_file[REG_RASTER]}) begin
                n_matches++;
                f = reg_file[REG_FLAGS] | 8'h01;
                if (reg_file[REG_ENABLE][0]) begin
                    irq_line = 1'b1;
                    f[7] = 1'b1;
                end
                reg_file[REG_FLAGS] = f;
            end
        endfunction

        // one clock tick of the beam
        function void advance_beam();
            beam_cycle = beam_cycle + 7'd1;
            if (beam_cycle == 7'd1 && beam_line == 9'd0) begin
                raster_match();
                den_seen = reg_file[REG_CTRL][4];
            end else if (beam_cycle >= line_cycles()) begin
                beam_cycle = '0;
                beam_line  = beam_line + 9'd1;
                if (beam_line >= frame_lines()) beam_line = '0;
                if (beam_line != 9'd0) raster_match();
            end
        endfunction

        function void write_register(logic [5:0] off, logic [7:0] v);
            logic [7:0] f;
            if (int'(off) >= REGISTER_COUNT) return;
            case (off)
                REG_CTRL: begin
                    // display enable only follows writes up to the den line
                    if (beam_line < DEN_LINE) den_seen = v[4];
                    else if (beam_line == DEN_LINE) den_seen = den_seen | v[4];
                    reg_file[off] = v;
                end
                REG_FLAGS: begin
                    f = reg_file[REG_FLAGS] & ~v;
                    if (f[3:0] == 4'd0) f[7] = 1'b0;
                    irq_line = f[7];
                    reg_file[REG_FLAGS] = f;
                end
                REG_ENABLE: begin
                    reg_file[off] = v;
                    if (v[0] && reg_file[REG_FLAGS][0]) begin
                        irq_line = 1'b1;
                        reg_file[REG_FLAGS][7] = 1'b1;
                    end
                end
                default: reg_file[off] = v;
            endcase
        endfunction

        function logic [7:0] read_register(logic [5:0] off);
            if (int'(off) >= REGISTER_COUNT) return 8'h00;
            case (off)
                REG_CTRL:   return {beam_line[8], reg_file[REG_CTRL][6:0]};
                REG_RASTER: return beam_line[7:0];
                default:    return reg_file[off];
            endcase
        endfunction

        function logic [1:0] stall_at_beam();
            if (!den_seen) return STALL_NONE;
            if (beam_line < BADLINE_FIRST || beam_line > BADLINE_LAST) return STALL_NONE;
            if (reg_file[REG_CTRL][2:0] != beam_line[2:0]) return STALL_NONE;
            if (beam_cycle < STALL_READ_X || beam_cycle > STALL_LAST_X) return STALL_NONE;
            return (beam_cycle >= STALL_FULL_X) ? STALL_FULL : STALL_RD;
        endfunction

        // accepted request: update the prediction and queue the result
        function void note_request(logic [1:0] cmd, logic [5:0] off, logic [7:0] data);
            beam_result_t want;
            want.rd = 8'h00;
            n_requests++;
            case (cmd)
                CMD_TICK: begin
                    advance_beam();
                    n_ticks++;
                end
                CMD_WRITE: begin
                    write_register(off, data);
                    n_writes++;
                end
                CMD_READ: begin
                    want.rd = read_register(off);
                    n_reads++;
                end
                default: n_unused++;
            endcase
            want.irq   = irq_line;
            want.stall = stall_at_beam();
            want.line  = beam_line;
            want.cyc   = beam_cycle;
            if (want.stall == STALL_RD) n_stall_rd++;
            if (want.stall == STALL_FULL) n_stall_full++;
            if (want.irq) n_irq_high++;
            expected_results.push_back(want);
        endfunction

        // accepted result: compare with the oldest prediction
        function void check_result(beam_result_t got);
            beam_result_t want;
            if (expected_results.size() == 0) begin
                $error("unexpected result: line %0d cycle %0d", got.line, got.cyc);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            n_checked++;
            if (got.rd !== want.rd) begin
                $error("read_data: expected %0h got %0h", want.rd, got.rd);
                errors++;
            end
            if (got.irq !== want.irq) begin
                $error("irq_out: expected %0d got %0d", want.irq, got.irq);
                errors++;
            end
            if (got.stall !== want.stall) begin
                $error("stall_level: expected %0d got %0d", want.stall, got.stall);
                errors++;
            end
            if (got.line !== want.line) begin
                $error("raster_line: expected %0d got %0d", want.line, got.line);
                errors++;
            end
            if (got.cyc !== want.cyc) begin
                $error("raster_cycle: expected %0d got %0d", want.cyc, got.cyc);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn           = 1'b0;
    logic        s_valid           = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command         = CMD_TICK;
    logic [5:0]  s_register_offset = '0;
    logic [7:0]  s_write_data      = '0;
    logic        m_valid;
    logic        m_ready           = 1'b0;
    logic [7:0]  m_read_data;
    logic        m_irq_out;
    logic [1:0]  m_stall_level;
    logic [8:0]  m_raster_line;
    logic [6:0]  m_raster_cycle;
    logic        psel              = 1'b0;
    logic        penable           = 1'b0;
    logic        pwrite            = 1'b0;
    logic [2:0]  paddr             = '0;
    logic [31:0] pwdata            = '0;
    logic [31:0] prdata;
    logic        pready;

    raster_scoreboard sb = new();
    logic             steady      = 1'b0;
    int               quiet_cycles = 0;

    video_raster_timing_irq_unit_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_register_offset (s_register_offset),
        .s_write_data      (s_write_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_read_data       (m_read_data),
        .m_irq_out         (m_irq_out),
        .m_stall_level     (m_stall_level),
        .m_raster_line     (m_raster_line),
        .m_raster_cycle    (m_raster_cycle),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result monitor, random back-pressure and activity tracking
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(beam_result_t'({m_read_data, m_irq_out, m_stall_level,
                                            m_raster_line, m_raster_cycle}));
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // watchdog
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("tb_video_raster_timing_irq_unit_core: FAIL");
        $finish;
    end

    // one request with random gaps in front; valid stays up after the handshake
    task automatic send_request(input logic [1:0] cmd, input logic [5:0] off,
                                input logic [7:0] data);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_command         <= cmd;
        s_register_offset <= off;
        s_write_data      <= data;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(cmd, off, data);
    endtask

    // random requests, biased toward raster compares near the beam and bad line matches
    task automatic run_requests(input int count, input int tick_pct);
        logic [1:0] cmd;
        logic [5:0] off;
        logic [7:0] data;
        logic [8:0] target;
        int         r;
        repeat (count) begin
            r      = $urandom_range(99);
            off    = 6'($urandom);
            data   = 8'($urandom);
            target = sb.beam_line + 9'($urandom_range(2));
            if (r < tick_pct) begin
                cmd = CMD_TICK;
            end else if (r < tick_pct + (100 - tick_pct) / 2) begin
                cmd = CMD_WRITE;
                case ($urandom_range(5))
                    0: begin
                        off = REG_CTRL;
                        if ($urandom_range(3) != 0) data[2:0] = sb.beam_line[2:0];
                        if ($urandom_range(3) != 0) data[4] = 1'b1;
                        if ($urandom_range(3) != 0) data[7] = target[8];
                    end
                    1: begin
                        off  = REG_RASTER;
                        data = target[7:0];
                    end
                    2: off = REG_FLAGS;
                    3: off = REG_ENABLE;
                    default: ;
                endcase
            end else if (r < 98) begin
                cmd = CMD_READ;
                case ($urandom_range(4))
                    0: off = REG_CTRL;
                    1: off = REG_RASTER;
                    2: off = REG_FLAGS;
                    3: off = REG_ENABLE;
                    default: ;
                endcase
            end else begin
                cmd = CMD_UNUSED;
            end
            send_request(cmd, off, data);
        end
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_NTSC_MODEL;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // drain the core, switch the frame format and read it back
    task automatic write_format(input logic ntsc_sel);
        logic [31:0] rdata;
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        apb_access(1'b1, 32'(ntsc_sel), rdata);
        sb.select_format(ntsc_sel);
        apb_access(1'b0, '0, rdata);
        if (rdata[0] !== ntsc_sel) begin
            $error("ntsc_model readback: expected %0d got %0d", ntsc_sel, rdata[0]);
            sb.errors++;
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values, window edges and the unused command
        send_request(CMD_READ, REG_CTRL, 8'h00);
        send_request(CMD_READ, REG_RASTER, 8'h00);
        send_request(CMD_READ, REG_FLAGS, 8'h00);
        send_request(CMD_READ, 6'h3F, 8'h00);
        // enable with a flag already pending raises the line, then acknowledge
        send_request(CMD_WRITE, REG_ENABLE, 8'h01);
        send_request(CMD_WRITE, REG_FLAGS, 8'h00);
        send_request(CMD_WRITE, REG_FLAGS, 8'h01);
        send_request(CMD_UNUSED, 6'h3F, 8'hFF);
        send_request(CMD_WRITE, 6'h00, 8'hFF);
        send_request(CMD_READ, 6'h00, 8'h00);
        send_request(CMD_WRITE, 6'h3F, 8'h00);
        send_request(CMD_READ, 6'h3F, 8'h00);
        // compare on line 0, display enable written late in the frame
        send_request(CMD_WRITE, REG_RASTER, 8'h00);
        send_request(CMD_WRITE, REG_CTRL, 8'h1B);
        send_request(CMD_WRITE, REG_ENABLE, 8'h01);
        send_request(CMD_TICK, 6'h00, 8'h00);
        send_request(CMD_TICK, 6'h00, 8'h00);
        send_request(CMD_READ, REG_FLAGS, 8'h00);
        // display enable copied early in the frame
        send_request(CMD_WRITE, REG_CTRL, 8'h08);
        send_request(CMD_WRITE, REG_FLAGS, 8'hFF);
        send_request(CMD_READ, REG_CTRL, 8'h00);
        send_request(CMD_WRITE, REG_CTRL, 8'h1B);
        send_request(CMD_TICK, 6'h3F, 8'hFF);

        run_requests(100, 55);

        // ntsc frame, starting at its wrap
        write_format(1'b1);
        run_requests(150, 55);

        // pal frame, back to back ticks through the first lines
        write_format(1'b0);
        steady = 1'b1;
        run_requests(250, 96);
        steady = 1'b0;
        run_requests(80, 55);

        write_format(1'b1);
        run_requests(50, 55);

        // drain and settle
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("covered %0d requests: %0d ticks, %0d writes, %0d reads, %0d unused",
                 sb.n_requests, sb.n_ticks, sb.n_writes, sb.n_reads, sb.n_unused);
        $display("%0d raster matches, %0d read stalls, %0d full stalls, %0d irq-high results",
                 sb.n_matches, sb.n_stall_rd, sb.n_stall_full, sb.n_irq_high);
        if (sb.errors == 0) begin
            $display("tb_video_raster_timing_irq_unit_core: PASS");
        end else begin
            $display("tb_video_raster_timing_irq_unit_core: FAIL");
        end
        $finish;
    end

endmodule
